/* hw/rtl/wstd_pkg.sv */
// Package for the work-stealing task dispatcher: parameter defaults, field widths,
// operation and result codes, and the command and status bundles shared by controller and datapath.
// No dependencies.
package wstd_pkg;

   localparam int MAX_WORKERS_DEF = 4;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int SPILL_DEPTH_DEF = 16;

   localparam int TAG_W     = 16;
   localparam int MODE_W    = 2;
   localparam int WORKER_W  = 2;
   localparam int STATUS_W  = 3;
   localparam int PENDING_W = 8;
   localparam int NUMW_W    = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [NUMW_W-1:0]    NUMW_RESET  = 3'd4;
   localparam logic [PENDING_W-1:0] PENDING_MAX = 8'd255;

   typedef enum logic [MODE_W-1:0] {
      MODE_SUBMIT = 2'd0,
      MODE_FETCH  = 2'd1,
      MODE_DONE   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_QUEUED_WORKER   = 3'd0,
      STAT_QUEUED_OVERFLOW = 3'd1,
      STAT_REJECTED        = 3'd2,
      STAT_OWN             = 3'd3,
      STAT_STOLEN          = 3'd4,
      STAT_OVERFLOW        = 3'd5,
      STAT_NONE            = 3'd6,
      STAT_COMPLETED       = 3'd7
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_RESP = 1'b1
   } fsm_type;

   typedef struct packed {
      logic accept;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_hold;
   } sts_type;

endpackage

/* hw/rtl/wstd_ctrl.sv */
// Controller state machine of the work-stealing task dispatcher.
// It sequences accept and result load; depends on wstd_pkg.
module wstd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  wstd_pkg::sts_type sts,
   output wstd_pkg::cmd_type cmd,
   output logic              req_tready
);

   wstd_pkg::fsm_type state_ff;
   wstd_pkg::fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wstd_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         wstd_pkg::FSM_IDLE: begin
            req_tready = 1'b1;
            if (sts.req_valid) begin
               cmd.accept = 1'b1;
               state_in   = wstd_pkg::FSM_RESP;
            end
         end
         wstd_pkg::FSM_RESP: begin
            if (!sts.rsp_hold) begin
               cmd.load = 1'b1;
               state_in = wstd_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = wstd_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/wstd_datapath.sv */
// Datapath of the work-stealing task dispatcher: deque and overflow memories, pointers,
// counters, the victim priority encoder and the result register; depends on wstd_pkg.
module wstd_datapath #(
   parameter int MAX_WORKERS = wstd_pkg::MAX_WORKERS_DEF,
   parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF,
   parameter int SPILL_DEPTH = wstd_pkg::SPILL_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wstd_pkg::cmd_type                cmd,
   output wstd_pkg::sts_type                sts,
   input  logic                             csr_wr_en,
   input  logic [wstd_pkg::NUMW_W-1:0]      csr_wr_data,
   input  logic                             req_tvalid,
   input  logic [wstd_pkg::MODE_W-1:0]      req_mode,
   input  logic [wstd_pkg::WORKER_W-1:0]    req_worker,
   input  logic [wstd_pkg::TAG_W-1:0]       req_tag,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wstd_pkg::STATUS_W-1:0]    rsp_status,
   output logic [wstd_pkg::TAG_W-1:0]       rsp_tag,
   output logic [wstd_pkg::WORKER_W-1:0]    rsp_who,
   output logic [wstd_pkg::PENDING_W-1:0]   rsp_pending
);

   localparam int IDX_W  = $clog2(MAX_WORKERS);
   localparam int NW_W   = $clog2(MAX_WORKERS + 1);
   localparam int SPAN   = 2 * QUEUE_DEPTH;
   localparam int PTR_W  = $clog2(SPAN);
   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int DQ_N   = MAX_WORKERS * QUEUE_DEPTH;
   localparam int DQA_W  = $clog2(DQ_N);
   localparam int SIW    = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
   localparam int SCW    = $clog2(SPILL_DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (32'(p) == SPAN - 1) ? '0 : PTR_W'(32'(p) + 1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      ptr_dec = (p == '0) ? PTR_W'(SPAN - 1) : PTR_W'(32'(p) - 1);
   endfunction

   function automatic logic [DQA_W-1:0] dq_addr_of(input logic [IDX_W-1:0] w,
                                                  input logic [PTR_W-1:0] p);
      logic [SLOT_W-1:0] slot;
      slot = (32'(p) >= QUEUE_DEPTH) ? SLOT_W'(32'(p) - QUEUE_DEPTH) : SLOT_W'(p);
      dq_addr_of = DQA_W'(DQA_W'(w) * DQA_W'(QUEUE_DEPTH)) + DQA_W'(slot);
   endfunction

   logic [wstd_pkg::TAG_W-1:0] dq_mem [DQ_N];
   logic [wstd_pkg::TAG_W-1:0] sp_mem [SPILL_DEPTH];

   logic [PTR_W-1:0]               top_ff    [MAX_WORKERS];
   logic [PTR_W-1:0]               bottom_ff [MAX_WORKERS];
   logic [SIW-1:0]                 sp_head_ff;
   logic [SCW-1:0]                 sp_count_ff;
   logic [IDX_W-1:0]               rr_ff;
   logic [wstd_pkg::PENDING_W-1:0] pending_ff;
   logic [wstd_pkg::NUMW_W-1:0]    numw_ff;

   logic [wstd_pkg::STATUS_W-1:0]  stat_ff;
   logic [wstd_pkg::WORKER_W-1:0]  who_ff;
   logic [wstd_pkg::TAG_W-1:0]     dq_rd_ff;
   logic [wstd_pkg::TAG_W-1:0]     sp_rd_ff;

   logic                           rsp_valid_ff;
   logic [wstd_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [wstd_pkg::TAG_W-1:0]     rsp_tag_ff;
   logic [wstd_pkg::WORKER_W-1:0]  rsp_who_ff;
   logic [wstd_pkg::PENDING_W-1:0] rsp_pending_ff;

   logic [NW_W-1:0]          nw;
   logic [MAX_WORKERS-1:0]   empty;
   logic [MAX_WORKERS-1:0]   full;
   logic [MAX_WORKERS-1:0]   cand;
   logic                     steal_hit;
   logic [IDX_W-1:0]         victim;
   logic [IDX_W-1:0]         target;
   logic [NW_W-1:0]          target_nx;
   logic [IDX_W-1:0]         rr_in;
   logic                     own_ok;
   logic [IDX_W-1:0]         own_idx;
   logic [SCW:0]             sp_sum;
   logic [SIW-1:0]           sp_tail;
   logic [SIW-1:0]           sp_head_nx;

   wstd_pkg::status_type          stat_c;
   logic [wstd_pkg::WORKER_W-1:0] who_c;
   logic                          dq_we;
   logic [DQA_W-1:0]              dq_addr;
   logic                          sp_push;
   logic                          sp_pop;
   logic                          bot_inc;
   logic                          bot_dec;
   logic                          top_inc;
   logic [IDX_W-1:0]              ptr_sel;
   logic                          pend_inc;
   logic                          pend_dec;
   logic                          rr_upd;

   always_comb begin
      if (numw_ff == '0) begin
         nw = NW_W'(1);
      end else if (32'(numw_ff) > MAX_WORKERS) begin
         nw = NW_W'(MAX_WORKERS);
      end else begin
         nw = NW_W'(numw_ff);
      end
   end

   always_comb begin
      logic [PTR_W:0] lvl;
      for (int w = 0; w < MAX_WORKERS; w++) begin
         lvl = {1'b0, bottom_ff[w]} - {1'b0, top_ff[w]};
         if (bottom_ff[w] < top_ff[w]) begin
            lvl = lvl + (PTR_W + 1)'(SPAN);
         end
         empty[w] = (bottom_ff[w] == top_ff[w]);
         full[w]  = (32'(lvl) == QUEUE_DEPTH);
         cand[w]  = (w < 32'(nw)) && (w != 32'(req_worker)) && !empty[w];
      end
   end

   always_comb begin
      steal_hit = 1'b0;
      victim    = '0;
      for (int v = MAX_WORKERS - 1; v >= 0; v--) begin
         if (cand[v]) begin
            steal_hit = 1'b1;
            victim    = IDX_W'(v);
         end
      end
   end

   assign target     = (32'(rr_ff) < 32'(nw)) ? rr_ff : '0;
   assign target_nx  = NW_W'(target) + NW_W'(1);
   assign rr_in      = (target_nx >= nw) ? '0 : IDX_W'(target_nx);
   assign own_idx    = IDX_W'(32'(req_worker));
   assign own_ok     = (32'(req_worker) < MAX_WORKERS) && !empty[own_idx];
   assign sp_sum     = (SCW + 1)'(sp_head_ff) + (SCW + 1)'(sp_count_ff);
   assign sp_tail    = (32'(sp_sum) >= SPILL_DEPTH) ? SIW'(32'(sp_sum) - SPILL_DEPTH)
                                                    : SIW'(sp_sum);
   assign sp_head_nx = (32'(sp_head_ff) == SPILL_DEPTH - 1) ? '0
                                                            : SIW'(32'(sp_head_ff) + 1);

   always_comb begin
      stat_c   = wstd_pkg::STAT_NONE;
      who_c    = '0;
      dq_we    = 1'b0;
      dq_addr  = '0;
      sp_push  = 1'b0;
      sp_pop   = 1'b0;
      bot_inc  = 1'b0;
      bot_dec  = 1'b0;
      top_inc  = 1'b0;
      ptr_sel  = '0;
      pend_inc = 1'b0;
      pend_dec = 1'b0;
      rr_upd   = 1'b0;
      case (req_mode)
         wstd_pkg::MODE_SUBMIT: begin
            rr_upd  = 1'b1;
            ptr_sel = target;
            who_c   = wstd_pkg::WORKER_W'(target);
            dq_addr = dq_addr_of(target, bottom_ff[target]);
            if (!full[target]) begin
               stat_c   = wstd_pkg::STAT_QUEUED_WORKER;
               dq_we    = 1'b1;
               bot_inc  = 1'b1;
               pend_inc = 1'b1;
            end else if (32'(sp_count_ff) < SPILL_DEPTH) begin
               stat_c   = wstd_pkg::STAT_QUEUED_OVERFLOW;
               sp_push  = 1'b1;
               pend_inc = 1'b1;
            end else begin
               stat_c = wstd_pkg::STAT_REJECTED;
            end
         end
         wstd_pkg::MODE_FETCH: begin
            if (own_ok) begin
               stat_c  = wstd_pkg::STAT_OWN;
               who_c   = req_worker;
               ptr_sel = own_idx;
               bot_dec = 1'b1;
               dq_addr = dq_addr_of(own_idx, ptr_dec(bottom_ff[own_idx]));
            end else if (steal_hit) begin
               stat_c  = wstd_pkg::STAT_STOLEN;
               who_c   = wstd_pkg::WORKER_W'(victim);
               ptr_sel = victim;
               top_inc = 1'b1;
               dq_addr = dq_addr_of(victim, top_ff[victim]);
            end else if (sp_count_ff != '0) begin
               stat_c = wstd_pkg::STAT_OVERFLOW;
               sp_pop = 1'b1;
            end
         end
         wstd_pkg::MODE_DONE: begin
            stat_c   = wstd_pkg::STAT_COMPLETED;
            pend_dec = 1'b1;
         end
         default: begin
            stat_c = wstd_pkg::STAT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && dq_we) begin
         dq_mem[dq_addr] <= req_tag;
      end
      if (cmd.accept) begin
         dq_rd_ff <= dq_mem[dq_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && sp_push) begin
         sp_mem[sp_tail] <= req_tag;
      end
      if (cmd.accept) begin
         sp_rd_ff <= sp_mem[sp_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < MAX_WORKERS; w++) begin
            top_ff[w]    <= '0;
            bottom_ff[w] <= '0;
         end
         sp_head_ff  <= '0;
         sp_count_ff <= '0;
         rr_ff       <= '0;
         pending_ff  <= '0;
         numw_ff     <= wstd_pkg::NUMW_RESET;
      end else begin
         if (csr_wr_en) begin
            numw_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            for (int w = 0; w < MAX_WORKERS; w++) begin
               if (32'(ptr_sel) == w) begin
                  if (bot_inc) begin
                     bottom_ff[w] <= ptr_inc(bottom_ff[w]);
                  end
                  if (bot_dec) begin
                     bottom_ff[w] <= ptr_dec(bottom_ff[w]);
                  end
                  if (top_inc) begin
                     top_ff[w] <= ptr_inc(top_ff[w]);
                  end
               end
            end
            if (rr_upd) begin
               rr_ff <= rr_in;
            end
            if (sp_push) begin
               sp_count_ff <= sp_count_ff + SCW'(1);
            end
            if (sp_pop) begin
               sp_count_ff <= sp_count_ff - SCW'(1);
               sp_head_ff  <= sp_head_nx;
            end
            if (pend_inc && pending_ff != wstd_pkg::PENDING_MAX) begin
               pending_ff <= pending_ff + 8'd1;
            end
            if (pend_dec && pending_ff != '0) begin
               pending_ff <= pending_ff - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         stat_ff <= stat_c;
         who_ff  <= who_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff  <= stat_ff;
         rsp_who_ff     <= who_ff;
         rsp_pending_ff <= pending_ff;
         case (wstd_pkg::status_type'(stat_ff))
            wstd_pkg::STAT_OWN,
            wstd_pkg::STAT_STOLEN:   rsp_tag_ff <= dq_rd_ff;
            wstd_pkg::STAT_OVERFLOW: rsp_tag_ff <= sp_rd_ff;
            default:                 rsp_tag_ff <= '0;
         endcase
      end
   end

   assign sts.req_valid = req_tvalid;
   assign sts.rsp_hold  = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_tag       = rsp_tag_ff;
   assign rsp_who       = rsp_who_ff;
   assign rsp_pending   = rsp_pending_ff;

endmodule

/* hw/rtl/work_stealing_task_dispatcher_top.sv */
// Work-stealing task dispatcher.
// The req channel takes one item per operation: tuser carries the mode (submit, fetch,
// completed), tdata the worker index and the task tag. The rsp channel returns exactly
// one item per request: tuser carries the status, tdata the handed-out tag, the deque
// index and the pending count after the item. The csr port sets the number of worker
// deques in use with a single write strobe; write it only while the block is idle.
// An item is handled in order: at the accepting edge the decision is made, pointers and
// counters update and the deque and overflow memories are written or read; then, once
// the result register can take it, the registered read data is loaded into it.
// A new item is accepted only after the result of the previous one has been loaded.
// The result register decouples the sides: a request is accepted while an earlier
// result still waits, and the block stalls only when the second result cannot be loaded.
// Reset (synchronous, active high) empties all deques and the overflow queue, clears the
// round-robin pointer and the pending count and sets the worker count to four.
// Depends on wstd_pkg, wstd_ctrl and wstd_datapath.
module work_stealing_task_dispatcher_top #(
   parameter int MAX_WORKERS = wstd_pkg::MAX_WORKERS_DEF,
   parameter int QUEUE_DEPTH = wstd_pkg::QUEUE_DEPTH_DEF,
   parameter int SPILL_DEPTH = wstd_pkg::SPILL_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [wstd_pkg::NUMW_W-1:0]       csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Bits 1:0 worker, 17:2 task_tag, 23:18 zero.
   input  logic [wstd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Bits 1:0 mode.
   input  logic [wstd_pkg::MODE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Bits 15:0 out_tag, 17:16 which_worker, 25:18 pending, 31:26 zero.
   output logic [wstd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Bits 2:0 status.
   output logic [wstd_pkg::STATUS_W-1:0]     rsp_tuser
);

   wstd_pkg::cmd_type              cmd;
   wstd_pkg::sts_type              sts;
   logic [wstd_pkg::TAG_W-1:0]     rsp_tag;
   logic [wstd_pkg::WORKER_W-1:0]  rsp_who;
   logic [wstd_pkg::PENDING_W-1:0] rsp_pending;

   wstd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .sts        (sts),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   wstd_datapath #(
      .MAX_WORKERS (MAX_WORKERS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SPILL_DEPTH (SPILL_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_mode    (req_tuser),
      .req_worker  (req_tdata[1:0]),
      .req_tag     (req_tdata[17:2]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_tag     (rsp_tag),
      .rsp_who     (rsp_who),
      .rsp_pending (rsp_pending)
   );

   assign rsp_tdata = {6'd0, rsp_pending, rsp_who, rsp_tag};

endmodule
